### rtl/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared types and constants for the elliptic curve scalar multiplier.
// ----------------------------------------------------------------------------
package ecsm_pkg;

  // Register index of the field modulus on the configuration port.
  localparam logic REG_FIELD_MODULUS = 1'b0;

  // Reset value of the field modulus.
  localparam logic [31:0] FIELD_MODULUS_RST = 32'd20959;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_RED_X,
    S_RED_Y,
    S_BIT,
    S_ADD,
    S_SQ,
    S_TRIPLE,
    S_INV,
    S_IDIV,
    S_IMUL,
    S_SDONE,
    S_S2,
    S_RX2,
    S_DMUL,
    S_RY,
    S_WB,
    S_OUT
  } state_e;

endpackage

### rtl/ec_scalar_multiply_top.sv
// ----------------------------------------------------------------------------
// ec_scalar_multiply_top
// Scalar multiplication on y^2 = x^3 + 7 over GF(p), right-to-left
// double-and-add with bit-serial field arithmetic.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block works on one item at a time and
// holds in_ready_o low while it is busy. It first reduces both coordinates by
// a bit-serial divider. Then, for each of the SCALAR_BITS scalar bits, it runs
// a doubling and, where the bit is set, an addition. A doubling costs four
// bit-serial modular multiplies plus bookkeeping, and a chord three. On top of
// that comes an extended Euclidean inversion, in which every step takes one
// division and one multiply. A 16-bit modulus needs about ten steps on average
// and at most about twenty-three. The time an item takes depends on the scalar
// and the inversions, and is set by the shared multiplier and divider.
// A finished result sits in an output register while the next beat is
// accepted. With a modulus below two the result is infinity.
module ec_scalar_multiply_top
  import ecsm_pkg::*;
#(
  parameter int FIELD_BITS  = 16,
  parameter int SCALAR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] base_x_i,
  input  logic [15:0] base_y_i,
  input  logic [15:0] scalar_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_x_o,
  output logic [15:0] result_y_o,
  output logic        result_infinity_o
);

  localparam int W  = FIELD_BITS;
  localparam int DW = (FIELD_BITS > 16) ? FIELD_BITS : 16;
  localparam int CW = $clog2(DW + 1);
  localparam int SB = SCALAR_BITS;
  localparam int BW = $clog2(SCALAR_BITS + 1);

  // Modular helpers on residues below p.
  function automatic logic [W-1:0] mod_add(input logic [W-1:0] a,
                                           input logic [W-1:0] b,
                                           input logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mod_sub(input logic [W-1:0] a,
                                           input logic [W-1:0] b,
                                           input logic [W-1:0] p);
    logic [W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, p} - {1'b0, b};
    end
    return s[W-1:0];
  endfunction

  state_e state_q, state_d, ret_q;

  logic [W-1:0]  p_q;
  logic [31:0]   wd32, rst32, rd32, x32, y32, k32;
  logic [DW-1:0] r0_dw;
  logic [15:0]   y_q;
  logic [SB-1:0] k_q;
  logic [BW-1:0] bit_cnt_q;
  logic          dbl_q;
  logic [CW-1:0] cnt_q;

  // Accumulator and running point.
  logic [W-1:0]  ax_q, ay_q, cx_q, cy_q;
  logic          ainf_q, cinf_q;
  // Addition temporaries.
  logic [W-1:0]  num_q, s_q, r0_q, r1_q, t0_q, t1_q, rx_q, ry_q;
  logic          rinf_q;
  // Shared divider and multiplier.
  logic [DW-1:0] div_n_q;
  logic [W:0]    div_r_q;
  logic [W-1:0]  div_d_q;
  logic [W-1:0]  mul_a_q, mul_b_q, mul_r_q;
  // Output register.
  logic          out_valid_q;
  logic [15:0]   res_x_q, res_y_q;
  logic          res_inf_q;

  // Operands of the current addition: acc + cur, or cur + cur.
  logic [W-1:0]  opa_x, opa_y;
  logic          opa_inf;
  assign opa_x   = dbl_q ? cx_q : ax_q;
  assign opa_y   = dbl_q ? cy_q : ay_q;
  assign opa_inf = dbl_q ? cinf_q : ainf_q;

  // Widening of narrow constants and ports.
  always_comb begin
    wd32  = {16'b0, pwdata[15:0]};
    rst32 = FIELD_MODULUS_RST;
    x32   = {16'b0, base_x_i};
    y32   = {16'b0, y_q};
    k32   = {16'b0, scalar_i};
    rd32  = '0;
    rd32[W-1:0] = p_q;
    r0_dw = '0;
    r0_dw[W-1:0] = r0_q;
  end

  // Accumulator coordinates widened for the 16-bit result ports.
  logic [31:0] ax32, ay32;
  always_comb begin
    ax32 = '0;
    ay32 = '0;
    ax32[W-1:0] = ax_q;
    ay32[W-1:0] = ay_q;
  end

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIELD_MODULUS) ? rd32 : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= rst32[W-1:0];
    end else if (psel && penable && pwrite && paddr[2] == REG_FIELD_MODULUS) begin
      p_q <= wd32[W-1:0];
    end
  end

  // Divider and multiplier step values.
  logic [W:0]    div_t;
  logic          div_ge;
  logic [W-1:0]  mul_r2, mul_r3;
  logic          div_last, mul_last;
  always_comb begin
    div_t    = {div_r_q[W-1:0], div_n_q[DW-1]};
    div_ge   = div_t >= {1'b0, div_d_q};
    mul_r2   = mod_add(mul_r_q, mul_r_q, p_q);
    mul_r3   = mul_b_q[W-1] ? mod_add(mul_r2, mul_a_q, p_q) : mul_r2;
    div_last = cnt_q == CW'(DW - 1);
    mul_last = cnt_q == CW'(W - 1);
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (p_q < W'(2)) ? S_OUT : S_DIV;
        end
      end
      S_DIV:   if (div_last) state_d = ret_q;
      S_MUL:   if (mul_last) state_d = ret_q;
      S_RED_X: state_d = S_DIV;
      S_RED_Y: state_d = S_BIT;
      S_BIT: begin
        if (bit_cnt_q == BW'(SB)) begin
          state_d = S_OUT;
        end else if (dbl_q || k_q[0]) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (opa_inf || cinf_q) begin
          state_d = S_WB;
        end else if (opa_x == cx_q) begin
          state_d = (opa_y != cy_q || opa_y == '0) ? S_WB : S_MUL;
        end else begin
          state_d = S_INV;
        end
      end
      S_SQ:     state_d = S_TRIPLE;
      S_TRIPLE: state_d = S_INV;
      S_INV: begin
        if (r1_q == '0) begin
          state_d = (r0_q == W'(1)) ? S_MUL : S_WB;
        end else begin
          state_d = S_DIV;
        end
      end
      S_IDIV:  state_d = S_MUL;
      S_IMUL:  state_d = S_INV;
      S_SDONE: state_d = S_MUL;
      S_S2:    state_d = S_RX2;
      S_RX2:   state_d = S_DMUL;
      S_DMUL:  state_d = S_MUL;
      S_RY:    state_d = S_WB;
      S_WB:    state_d = S_BIT;
      S_OUT:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output beat valid flag: set when a result is loaded, cleared when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Control registers of the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      dbl_q       <= 1'b0;
      bit_cnt_q   <= '0;
      ainf_q      <= 1'b1;
      cinf_q      <= 1'b1;
      rinf_q      <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q     <= '0;
          ret_q     <= S_RED_X;
          dbl_q     <= 1'b0;
          bit_cnt_q <= '0;
          ainf_q    <= 1'b1;
          cinf_q    <= 1'b1;
        end
        S_DIV, S_MUL: cnt_q <= cnt_q + CW'(1);
        S_RED_X: begin
          cnt_q <= '0;
          ret_q <= S_RED_Y;
        end
        S_RED_Y: cinf_q <= 1'b0;
        S_BIT: begin
          if (bit_cnt_q != BW'(SB) && !dbl_q && !k_q[0]) begin
            dbl_q <= 1'b1;
          end
        end
        S_ADD: begin
          cnt_q <= '0;
          ret_q <= S_SQ;
          if (opa_inf) begin
            rinf_q <= cinf_q;
          end else if (cinf_q) begin
            rinf_q <= opa_inf;
          end else begin
            rinf_q <= 1'b1;
          end
        end
        S_INV: begin
          cnt_q <= '0;
          ret_q <= (r1_q == '0) ? S_SDONE : S_IDIV;
        end
        S_IDIV: begin
          cnt_q <= '0;
          ret_q <= S_IMUL;
        end
        S_SDONE: begin
          cnt_q <= '0;
          ret_q <= S_S2;
        end
        S_DMUL: begin
          cnt_q <= '0;
          ret_q <= S_RY;
        end
        S_RY: rinf_q <= 1'b0;
        S_WB: begin
          if (dbl_q) begin
            cinf_q    <= rinf_q;
            bit_cnt_q <= bit_cnt_q + BW'(1);
            dbl_q     <= 1'b0;
          end else begin
            ainf_q <= rinf_q;
            dbl_q  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        y_q     <= base_y_i;
        k_q     <= k32[SB-1:0];
        div_n_q <= x32[DW-1:0];
        div_r_q <= '0;
        div_d_q <= p_q;
        ax_q    <= '0;
        ay_q    <= '0;
      end
      S_DIV: begin
        div_n_q <= {div_n_q[DW-2:0], div_ge};
        div_r_q <= div_ge ? (div_t - {1'b0, div_d_q}) : div_t;
      end
      S_MUL: begin
        mul_r_q <= mul_r3;
        mul_b_q <= {mul_b_q[W-2:0], 1'b0};
      end
      S_RED_X: begin
        cx_q    <= div_r_q[W-1:0];
        div_n_q <= y32[DW-1:0];
        div_r_q <= '0;
      end
      S_RED_Y: cy_q <= div_r_q[W-1:0];
      S_ADD: begin
        if (opa_inf) begin
          rx_q <= cx_q;
          ry_q <= cy_q;
        end else if (cinf_q) begin
          rx_q <= opa_x;
          ry_q <= opa_y;
        end
        mul_a_q <= opa_x;
        mul_b_q <= opa_x;
        mul_r_q <= '0;
        num_q   <= mod_sub(cy_q, opa_y, p_q);
        r0_q    <= p_q;
        r1_q    <= mod_sub(cx_q, opa_x, p_q);
        t0_q    <= '0;
        t1_q    <= W'(1);
      end
      S_SQ: num_q <= mod_add(mul_r_q, mul_r_q, p_q);
      S_TRIPLE: begin
        num_q <= mod_add(num_q, mul_r_q, p_q);
        r1_q  <= mod_add(opa_y, opa_y, p_q);
      end
      S_INV: begin
        mul_a_q <= num_q;
        mul_b_q <= t0_q;
        mul_r_q <= '0;
        div_n_q <= r0_dw;
        div_r_q <= '0;
        div_d_q <= r1_q;
      end
      S_IDIV: begin
        mul_a_q <= div_n_q[W-1:0];
        mul_b_q <= t1_q;
        mul_r_q <= '0;
      end
      S_IMUL: begin
        t0_q <= t1_q;
        t1_q <= mod_sub(t0_q, mul_r_q, p_q);
        r0_q <= r1_q;
        r1_q <= div_r_q[W-1:0];
      end
      S_SDONE: begin
        s_q     <= mul_r_q;
        mul_a_q <= mul_r_q;
        mul_b_q <= mul_r_q;
        mul_r_q <= '0;
      end
      S_S2:  rx_q <= mod_sub(mul_r_q, opa_x, p_q);
      S_RX2: rx_q <= mod_sub(rx_q, cx_q, p_q);
      S_DMUL: begin
        mul_a_q <= s_q;
        mul_b_q <= mod_sub(opa_x, rx_q, p_q);
        mul_r_q <= '0;
      end
      S_RY: ry_q <= mod_sub(mul_r_q, opa_y, p_q);
      S_WB: begin
        if (dbl_q) begin
          cx_q <= rx_q;
          cy_q <= ry_q;
          k_q  <= k_q >> 1;
        end else begin
          ax_q <= rx_q;
          ay_q <= ry_q;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          res_inf_q <= ainf_q;
          res_x_q   <= ainf_q ? 16'b0 : ax32[15:0];
          res_y_q   <= ainf_q ? 16'b0 : ay32[15:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o        = state_q == S_IDLE;
  assign out_valid_o       = out_valid_q;
  assign result_x_o        = res_x_q;
  assign result_y_o        = res_y_q;
  assign result_infinity_o = res_inf_q;

endmodule
